### design/affine_transform_accumulator_unit_macros.svh
// Assertion macros for the affine transform accumulator checker.
// Expects clk and rst in the scope where a macro is used.
`ifndef AFFINE_TRANSFORM_ACCUMULATOR_UNIT_MACROS_SVH
`define AFFINE_TRANSFORM_ACCUMULATOR_UNIT_MACROS_SVH

// Checked outside reset only.
`define ATA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define ATA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/ata_pkg.sv
// Shared types, constants and sine/cosine quarter tables for the affine
// transform accumulator. No dependencies.
package ata_pkg;

  localparam int FRAC_BITS        = 16;
  localparam int SINE_TABLE_DEPTH = 1024;

  localparam int DW        = 32;
  localparam int ANG_W     = 18;
  localparam int NUM_ENT   = 12;
  localparam int IDX_W     = 4;
  localparam int FULL_TURN = 92160;
  localparam int RED_W     = 17;
  localparam int KW        = $clog2(SINE_TABLE_DEPTH);
  localparam int JW        = KW - 2;
  localparam int QD        = SINE_TABLE_DEPTH / 4;
  localparam int TW        = FRAC_BITS + 2;
  localparam int NW        = RED_W + KW;
  localparam int RS        = NW + 17;
  localparam int RW        = NW + 1;
  localparam int PW        = 2 * DW - FRAC_BITS;
  localparam int AW        = PW + 2;

  localparam logic [RW-1:0] RECIP = RW'((64'd1 << RS) / FULL_TURN);
  localparam logic signed [DW-1:0] ONE = DW'(64'd1 << FRAC_BITS);

  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    REQ_IDENT     = 2'd0,
    REQ_TRANSLATE = 2'd1,
    REQ_ROTATE    = 2'd2,
    REQ_APPLY     = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_RUN,
    ST_PUSH
  } state_t;

  typedef enum logic [2:0] {
    OP_X,
    OP_Y,
    OP_Z,
    OP_COS,
    OP_SIN
  } opsel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_M,
    ACC_LOAD_P,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef enum logic {
    WR_ACC,
    WR_HOLD
  } wr_src_t;

  typedef struct packed {
    logic             in_load;
    logic             ident;
    logic [IDX_W-1:0] rd_idx;
    opsel_t           op_sel;
    acc_op_t          acc_op;
    logic             hold_en;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    wr_src_t          wr_src;
    logic             res_en;
    logic [1:0]       res_row;
    logic             out_load;
  } dp_cmd_t;

  typedef logic [TW-1:0] qtab_t [QD];

  function automatic longint unsigned m30(input longint unsigned a,
                                          input longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic longint unsigned horner(input longint unsigned a2,
                                             input longint unsigned inner,
                                             input int i, input bit is_cos);
    longint unsigned p;
    longint unsigned t;
    p = m30(a2, inner);
    if (!is_cos) begin
      case (i)
        0:       t = p / 156;
        1:       t = p / 110;
        2:       t = p / 72;
        3:       t = p / 42;
        4:       t = p / 20;
        default: t = p / 6;
      endcase
    end else begin
      case (i)
        0:       t = p / 132;
        1:       t = p / 90;
        2:       t = p / 56;
        3:       t = p / 30;
        4:       t = p / 12;
        default: t = p / 2;
      endcase
    end
    return (t < Q30_ONE) ? Q30_ONE - t : 64'd0;
  endfunction

  function automatic logic [TW-1:0] q_round(input longint unsigned v);
    longint unsigned r;
    r = (v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    return TW'(r);
  endfunction

  // First quadrant magnitudes, rounded to FRAC_BITS fraction bits.
  function automatic qtab_t build_qtab(input bit is_cos);
    qtab_t t;
    longint unsigned a;
    longint unsigned a2;
    longint unsigned si;
    longint unsigned co;
    for (int j = 0; j < QD; j++) begin
      a  = (64'(4 * j) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
      a2 = m30(a, a);
      si = Q30_ONE;
      co = Q30_ONE;
      for (int i = 0; i < 6; i++) begin
        si = horner(a2, si, i, 1'b0);
        co = horner(a2, co, i, 1'b1);
      end
      t[j] = is_cos ? q_round(co) : q_round(m30(a, si));
    end
    return t;
  endfunction

  localparam qtab_t SIN_Q = build_qtab(1'b0);
  localparam qtab_t COS_Q = build_qtab(1'b1);

endpackage

### design/ata_in_if.sv
// Request channel: valid/ready plus the request word.
// Depends on ata_pkg.
interface ata_in_if;
  import ata_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              req_type;
  logic signed [DW-1:0]    arg_x;
  logic signed [DW-1:0]    arg_y;
  logic signed [DW-1:0]    arg_z;
  logic signed [ANG_W-1:0] angle_deg;
  modport source (output valid, req_type, arg_x, arg_y, arg_z, angle_deg, input ready);
  modport sink   (input valid, req_type, arg_x, arg_y, arg_z, angle_deg, output ready);
endinterface

### design/ata_out_if.sv
// Result channel: valid/ready plus the transformed point.
// Depends on ata_pkg.
interface ata_out_if;
  import ata_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] x_out;
  logic signed [DW-1:0] y_out;
  logic signed [DW-1:0] z_out;
  modport source (output valid, x_out, y_out, z_out, input ready);
  modport sink   (input valid, x_out, y_out, z_out, output ready);
endinterface

### design/ata_ctrl.sv
// Sequencer: steps rows and micro-steps for each request, drives the
// datapath command word and both handshakes. Depends on ata_pkg.
module ata_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       in_req,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output ata_pkg::dp_cmd_t cmd
);
  import ata_pkg::*;

  state_t     state, state_next;
  req_t       op, op_next;
  logic [1:0] row, row_next;
  logic [2:0] step, step_next;
  logic       out_valid_next;
  logic [IDX_W-1:0] base;
  logic       last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op        <= REQ_IDENT;
      row       <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      op        <= op_next;
      row       <= row_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  assign base = {row, 2'b00};

  always_comb begin
    state_next     = state;
    op_next        = op;
    row_next       = row;
    step_next      = step;
    out_valid_next = out_valid & ~out_ready;
    in_ready       = 1'b0;
    last           = 1'b0;
    cmd            = '0;
    cmd.res_row    = row;

    unique case (state)
      ST_IDLE: begin
        // refuse words while reset is held
        in_ready = ~rst;
        if (in_valid && !rst) begin
          cmd.in_load = 1'b1;
          op_next     = req_t'(in_req);
          row_next    = '0;
          step_next   = '0;
          state_next  = (req_t'(in_req) == REQ_ROTATE) ? ST_ANGLE : ST_RUN;
        end
      end
      // wait for the angle-to-sine pipeline to settle
      ST_ANGLE: begin
        step_next = step + 3'd1;
        if (step == 3'd3) begin
          step_next  = '0;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        unique case (op) inside
          REQ_IDENT: begin
            cmd.ident  = 1'b1;
            state_next = ST_IDLE;
          end
          REQ_TRANSLATE, REQ_APPLY: begin
            case (step)
              3'd0: begin
                cmd.rd_idx = base + IDX_W'(3);
                cmd.acc_op = ACC_LOAD_M;
              end
              3'd1: begin
                cmd.rd_idx = base;
                cmd.op_sel = OP_X;
              end
              3'd2: begin
                cmd.rd_idx = base + IDX_W'(1);
                cmd.op_sel = OP_Y;
                cmd.acc_op = ACC_ADD;
              end
              3'd3: begin
                cmd.rd_idx = base + IDX_W'(2);
                cmd.op_sel = OP_Z;
                cmd.acc_op = ACC_ADD;
              end
              3'd4: cmd.acc_op = ACC_ADD;
              default: begin
                last = 1'b1;
                if (op == REQ_APPLY) begin
                  cmd.res_en = 1'b1;
                end else begin
                  cmd.wr_en  = 1'b1;
                  cmd.wr_idx = base + IDX_W'(3);
                  cmd.wr_src = WR_ACC;
                end
              end
            endcase
          end
          REQ_ROTATE: begin
            case (step)
              3'd0: begin
                cmd.rd_idx = base;
                cmd.op_sel = OP_COS;
              end
              3'd1: begin
                cmd.rd_idx = base + IDX_W'(1);
                cmd.op_sel = OP_SIN;
                cmd.acc_op = ACC_LOAD_P;
              end
              3'd2: begin
                cmd.rd_idx = base + IDX_W'(1);
                cmd.op_sel = OP_COS;
                cmd.acc_op = ACC_ADD;
              end
              3'd3: begin
                // park the new column 0 value, start column 1
                cmd.rd_idx  = base;
                cmd.op_sel  = OP_SIN;
                cmd.hold_en = 1'b1;
                cmd.acc_op  = ACC_LOAD_P;
              end
              3'd4: cmd.acc_op = ACC_SUB;
              3'd5: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_idx = base + IDX_W'(1);
                cmd.wr_src = WR_ACC;
              end
              default: begin
                last       = 1'b1;
                cmd.wr_en  = 1'b1;
                cmd.wr_idx = base;
                cmd.wr_src = WR_HOLD;
              end
            endcase
          end
          default: state_next = ST_IDLE;
        endcase
        if (op != REQ_IDENT) begin
          step_next = step + 3'd1;
          if (last) begin
            step_next = '0;
            if (row == 2'd2) begin
              state_next = (op == REQ_APPLY) ? ST_PUSH : ST_IDLE;
            end else begin
              row_next = row + 2'd1;
            end
          end
        end
      end
      ST_PUSH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### design/ata_dpath.sv
// Datapath: matrix registers, angle-to-sine pipeline, shared multiplier,
// rounding accumulator and result registers. Depends on ata_pkg.
module ata_dpath (
  input  logic                           clk,
  input  logic                           rst,
  input  ata_pkg::dp_cmd_t               cmd,
  input  logic signed [ata_pkg::DW-1:0]  arg_x,
  input  logic signed [ata_pkg::DW-1:0]  arg_y,
  input  logic signed [ata_pkg::DW-1:0]  arg_z,
  input  logic signed [ata_pkg::ANG_W-1:0] angle_deg,
  output logic signed [ata_pkg::DW-1:0]  x_out,
  output logic signed [ata_pkg::DW-1:0]  y_out,
  output logic signed [ata_pkg::DW-1:0]  z_out
);
  import ata_pkg::*;

  localparam logic signed [ANG_W+1:0] FT   = (ANG_W + 2)'(FULL_TURN);
  localparam logic signed [AW-1:0]    SMAX = {{(AW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
  localparam logic signed [AW-1:0]    SMIN = ~SMAX;

  function automatic logic signed [DW-1:0] sat(input logic signed [AW-1:0] v);
    if (v > SMAX) return SMAX[DW-1:0];
    if (v < SMIN) return SMIN[DW-1:0];
    return v[DW-1:0];
  endfunction

  logic signed [DW-1:0]    mat [NUM_ENT];
  logic signed [DW-1:0]    ax, ay, az;
  logic signed [ANG_W-1:0] ang;

  // angle to table index
  logic signed [ANG_W+1:0] aw, red_w;
  logic [NW-1:0]           n;
  logic [NW+RW-1:0]        rp;
  logic [KW:0]             qe, kc;
  logic [NW:0]             rem;
  logic [KW-1:0]           k;
  logic [TW-1:0]           sv, cv;
  logic signed [DW-1:0]    sv_w, cv_w;
  logic signed [DW-1:0]    sin_v, cos_v;

  // multiply-accumulate
  logic signed [DW-1:0]    rd, opnd;
  logic signed [2*DW-1:0]  prod;
  logic signed [PW-1:0]    tr;
  logic signed [AW-1:0]    term, acc;
  logic signed [DW-1:0]    acc_sat, hold;
  logic signed [DW-1:0]    res [3];

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      ax  <= arg_x;
      ay  <= arg_y;
      az  <= arg_z;
      ang <= angle_deg;
    end
  end

  always_comb begin
    aw = (ANG_W + 2)'(ang);
    if (aw >= FT)        red_w = aw - FT;
    else if (aw >= 0)    red_w = aw;
    else if (aw >= -FT)  red_w = aw + FT;
    else                 red_w = aw + FT + FT;
  end

  assign qe  = rp[NW+RW-1:RS];
  assign rem = {1'b0, n} - (NW + 1)'((NW + 1)'(qe) * (NW + 1)'(FULL_TURN));

  always_comb begin
    kc = (rem >= (NW + 1)'(FULL_TURN)) ? qe + (KW + 1)'(1) : qe;
    if (kc == (KW + 1)'(SINE_TABLE_DEPTH)) kc = '0;
  end

  assign sv   = SIN_Q[k[JW-1:0]];
  assign cv   = COS_Q[k[JW-1:0]];
  assign sv_w = DW'(sv);
  assign cv_w = DW'(cv);

  // free-running: latched angle flows through n, rp and k to sin_v/cos_v
  always_ff @(posedge clk) begin
    n  <= {red_w[RED_W-1:0], {KW{1'b0}}} + NW'(FULL_TURN / 2);
    rp <= (NW + RW)'(n) * (NW + RW)'(RECIP);
    k  <= kc[KW-1:0];
    case (k[KW-1:KW-2])
      2'd0: begin
        sin_v <= sv_w;
        cos_v <= cv_w;
      end
      2'd1: begin
        sin_v <= cv_w;
        cos_v <= -sv_w;
      end
      2'd2: begin
        sin_v <= -sv_w;
        cos_v <= -cv_w;
      end
      default: begin
        sin_v <= -cv_w;
        cos_v <= sv_w;
      end
    endcase
  end

  assign rd = mat[cmd.rd_idx];

  always_comb begin
    case (cmd.op_sel)
      OP_X:    opnd = ax;
      OP_Y:    opnd = ay;
      OP_Z:    opnd = az;
      OP_COS:  opnd = cos_v;
      OP_SIN:  opnd = sin_v;
      default: opnd = '0;
    endcase
  end

  // round to nearest, ties up: floor of the shifted product plus the
  // first dropped bit
  assign tr      = prod[2*DW-1:FRAC_BITS];
  assign term    = AW'(tr);
  assign acc_sat = sat(acc);

  always_ff @(posedge clk) begin
    prod <= rd * opnd;
    case (cmd.acc_op)
      ACC_LOAD_M: acc <= AW'(rd);
      ACC_LOAD_P: acc <= term + {{(AW - 1){1'b0}}, prod[FRAC_BITS-1]};
      ACC_ADD:    acc <= acc + term + {{(AW - 1){1'b0}}, prod[FRAC_BITS-1]};
      ACC_SUB:    acc <= acc - term - {{(AW - 1){1'b0}}, prod[FRAC_BITS-1]};
      default:    acc <= acc;
    endcase
    if (cmd.hold_en) hold <= acc_sat;
    if (cmd.res_en) res[cmd.res_row] <= acc_sat;
    if (cmd.out_load) begin
      x_out <= res[0];
      y_out <= res[1];
      z_out <= res[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.ident) begin
      for (int i = 0; i < NUM_ENT; i++) begin
        mat[i] <= (i == 0 || i == 5 || i == 10) ? ONE : '0;
      end
    end else if (cmd.wr_en) begin
      mat[cmd.wr_idx] <= (cmd.wr_src == WR_ACC) ? acc_sat : hold;
    end
  end

endmodule

### design/affine_transform_accumulator_unit.sv
// Channel  Dir  Handshake    Word
// req      in   valid/ready  req_type, arg_x, arg_y, arg_z, angle_deg
// rsp      out  valid/ready  x_out, y_out, z_out (apply only)
//
// One request at a time; one 32x32 multiplier shared over every product.
// Apply adds a final step to load the result register; rotate first
// waits for the angle-to-sine pipeline.
// Synchronous reset loads the identity matrix; no clearing pass.
// A pending result stalls only the next apply, at its final load.
// Top level: ties controller and datapath to the channels. Depends on
// ata_pkg, ata_in_if, ata_out_if, ata_ctrl, ata_dpath.
module affine_transform_accumulator_unit (
  input logic       clk,
  input logic       rst,
  ata_in_if.sink    req,
  ata_out_if.source rsp
);
  import ata_pkg::*;

  dp_cmd_t cmd;

  ata_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_req    (req.req_type),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  ata_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .arg_x     (req.arg_x),
    .arg_y     (req.arg_y),
    .arg_z     (req.arg_z),
    .angle_deg (req.angle_deg),
    .x_out     (rsp.x_out),
    .y_out     (rsp.y_out),
    .z_out     (rsp.z_out)
  );

endmodule

### design/ata_chk.sv
// Port-level checker for the affine transform accumulator, bound to the
// top level. Depends on ata_pkg and the macros header.
`include "affine_transform_accumulator_unit_macros.svh"

module ata_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [ata_pkg::DW-1:0] x_out,
  input logic signed [ata_pkg::DW-1:0] y_out,
  input logic signed [ata_pkg::DW-1:0] z_out
);
  import ata_pkg::*;

  `ATA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `ATA_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(x_out) && $stable(y_out) && $stable(z_out), "result changed while stalled")
  `ATA_ASSERT(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "second word taken while busy")
  `ATA_ASSERT(a_push_busy, $rose(out_valid) |-> $past(!in_ready), "result raised while idle")
  `ATA_ASSERT_ALWAYS(a_reset_clear, rst |=> !out_valid, "result valid after reset")

endmodule

bind affine_transform_accumulator_unit ata_chk u_ata_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .x_out     (rsp.x_out),
  .y_out     (rsp.y_out),
  .z_out     (rsp.z_out)
);
